FILE: design/dnsap_pkg.sv
// ----------------------------------------------------------------------------
// DNS answer address parser package
// Shared types, field widths and result status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package dnsap_pkg;

  // Payload field types.
  typedef logic [7:0]  payload_t;
  typedef logic [2:0]  status_t;
  typedef logic [31:0] address_t;
  typedef logic [15:0] txn_id_t;

  // Result status codes.
  localparam status_t ST_FOUND       = 3'd0;
  localparam status_t ST_NO_ANSWERS  = 3'd1;
  localparam status_t ST_WRONG_ID    = 3'd2;
  localparam status_t ST_BAD_LENGTH  = 3'd3;
  localparam status_t ST_NOT_FOUND   = 3'd4;

endpackage : dnsap_pkg

`default_nettype wire

FILE: design/dnsap_in_if.sv
// ----------------------------------------------------------------------------
// DNS answer address parser input channel
// Carries one payload byte per beat, with a mark on the final byte.
// ----------------------------------------------------------------------------
`default_nettype none

interface dnsap_in_if;
  import dnsap_pkg::*;

  logic     valid;
  logic     ready;
  payload_t payload_byte;
  logic     last;

  modport source (output valid, output payload_byte, output last, input ready);
  modport sink   (input valid, input payload_byte, input last, output ready);

endinterface : dnsap_in_if

`default_nettype wire

FILE: design/dnsap_out_if.sv
// ----------------------------------------------------------------------------
// DNS answer address parser result channel
// Carries one status and address per beat, one beat per message.
// ----------------------------------------------------------------------------
`default_nettype none

interface dnsap_out_if;
  import dnsap_pkg::*;

  logic     valid;
  logic     ready;
  status_t  status;
  address_t address;

  modport source (output valid, output status, output address, input ready);
  modport sink   (input valid, input status, input address, output ready);

endinterface : dnsap_out_if

`default_nettype wire

FILE: design/dns_answer_address_parser_top.sv
// ----------------------------------------------------------------------------
// DNS answer address parser
// Walks a DNS response one byte per beat and reports the first IPv4 address.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel takes the response payload one byte per beat, with
//   last high on the final byte. The result channel gives exactly one beat
//   per message: the status and, when an address record was found, the
//   IPv4 address (zero otherwise). expected_id is written through cfg_we and
//   cfg_wdata while no message is in flight.
//   Each byte is parsed in the cycle it is accepted; a result appears on the
//   output register in the cycle after the byte that completes it. One byte
//   is accepted every cycle while the output register is free or being
//   drained; the parser state registers are updated once per beat.
//   The input is held off only while a result sits in the output register
//   and the receiver is not taking it. After a result, the rest of the
//   message is consumed without further output.
//   Synchronous reset clears the parser, the output valid flag and
//   expected_id; a byte may be accepted in the first cycle after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module dns_answer_address_parser_top (
  input  wire logic              clk,
  input  wire logic              rst,
  dnsap_in_if.sink               in,
  dnsap_out_if.source            out,
  input  wire logic              cfg_we,
  input  wire dnsap_pkg::txn_id_t cfg_wdata
);
  import dnsap_pkg::*;

  // Parser phase codes.
  localparam logic [3:0] PH_HDR         = 4'd0;
  localparam logic [3:0] PH_QNAME_FIRST = 4'd1;
  localparam logic [3:0] PH_QNAME_REST  = 4'd2;
  localparam logic [3:0] PH_QNAME_PTR   = 4'd3;
  localparam logic [3:0] PH_QFIX        = 4'd4;
  localparam logic [3:0] PH_ANAME_FIRST = 4'd5;
  localparam logic [3:0] PH_ANAME_REST  = 4'd6;
  localparam logic [3:0] PH_ANAME_PTR   = 4'd7;
  localparam logic [3:0] PH_ATYPE       = 4'd8;
  localparam logic [3:0] PH_AFIX        = 4'd9;
  localparam logic [3:0] PH_ALEN        = 4'd10;
  localparam logic [3:0] PH_ADDR        = 4'd11;
  localparam logic [3:0] PH_ADATA       = 4'd12;
  localparam logic [3:0] PH_DONE        = 4'd13;

  // Byte counts and field values.
  localparam logic [3:0]  HDR_LAST   = 4'd11;
  localparam logic [3:0]  QFIX_LAST  = 4'd3;
  localparam logic [3:0]  AFIX_LAST  = 4'd5;
  localparam logic [3:0]  ADDR_LAST  = 4'd3;
  localparam logic [3:0]  PAIR_LAST  = 4'd1;
  localparam logic [15:0] TYPE_ADDR  = 16'd1;
  localparam logic [15:0] ADDR_LEN   = 16'd4;
  localparam payload_t    PTR_MASK   = 8'hc0;

  logic [3:0]  parse_phase, parse_phase_next;
  logic [3:0]  byte_counter, byte_counter_next;
  txn_id_t     captured_id, captured_id_next;
  logic        answers_present, answers_present_next;
  logic [15:0] record_type, record_type_next;
  logic [15:0] record_length, record_length_next;
  address_t    address_accumulator, address_accumulator_next;
  logic        reported, reported_next;
  txn_id_t     expected_id;

  logic        out_valid;
  status_t     out_status;
  address_t    out_address;

  logic        accept;
  logic        emit;
  status_t     emit_status;
  address_t    emit_address;
  payload_t    b;
  logic        ptr_first;

  assign accept    = in.valid && in.ready;
  assign b         = in.payload_byte;
  assign ptr_first = (b & PTR_MASK) == PTR_MASK;

  // Input is taken whenever the output register is free or being drained.
  assign in.ready    = !out_valid || out.ready;
  assign out.valid   = out_valid;
  assign out.status  = out_status;
  assign out.address = out_address;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_id <= '0;
    end else if (cfg_we) begin
      expected_id <= cfg_wdata;
    end
  end

  // Next-state logic for one accepted byte.
  always_comb begin
    parse_phase_next         = parse_phase;
    byte_counter_next        = byte_counter;
    captured_id_next         = captured_id;
    answers_present_next     = answers_present;
    record_type_next         = record_type;
    record_length_next       = record_length;
    address_accumulator_next = address_accumulator;
    reported_next            = reported;
    emit                     = 1'b0;
    emit_status              = ST_FOUND;
    emit_address             = '0;

    case (parse_phase)
      PH_HDR: begin
        if (byte_counter == 4'd0) begin
          captured_id_next = {b, 8'h00};
        end else if (byte_counter == 4'd1) begin
          captured_id_next = {captured_id[15:8], b};
        end else if ((byte_counter == 4'd6 || byte_counter == 4'd7) && b != 8'h00) begin
          answers_present_next = 1'b1;
        end
        if (byte_counter == HDR_LAST) begin
          byte_counter_next = '0;
          if (!answers_present) begin
            emit        = 1'b1;
            emit_status = ST_NO_ANSWERS;
          end else if (captured_id != expected_id) begin
            emit        = 1'b1;
            emit_status = ST_WRONG_ID;
          end else begin
            parse_phase_next = PH_QNAME_FIRST;
          end
        end else begin
          byte_counter_next = byte_counter + 4'd1;
        end
      end
      PH_QNAME_FIRST: begin
        if (ptr_first) begin
          parse_phase_next = PH_QNAME_PTR;
        end else if (b == 8'h00) begin
          parse_phase_next = PH_QFIX;
        end else begin
          parse_phase_next = PH_QNAME_REST;
        end
      end
      PH_QNAME_REST: begin
        if (b == 8'h00) begin
          parse_phase_next = PH_QFIX;
        end
      end
      PH_QNAME_PTR: begin
        parse_phase_next = PH_QFIX;
      end
      PH_QFIX: begin
        if (byte_counter == QFIX_LAST) begin
          byte_counter_next = '0;
          parse_phase_next  = PH_ANAME_FIRST;
        end else begin
          byte_counter_next = byte_counter + 4'd1;
        end
      end
      PH_ANAME_FIRST: begin
        byte_counter_next = '0;
        if (ptr_first) begin
          parse_phase_next = PH_ANAME_PTR;
        end else if (b == 8'h00) begin
          parse_phase_next = PH_ATYPE;
        end else begin
          parse_phase_next = PH_ANAME_REST;
        end
      end
      PH_ANAME_REST: begin
        if (b == 8'h00) begin
          parse_phase_next = PH_ATYPE;
        end
      end
      PH_ANAME_PTR: begin
        parse_phase_next = PH_ATYPE;
      end
      PH_ATYPE: begin
        record_type_next = {record_type[7:0], b};
        if (byte_counter == PAIR_LAST) begin
          byte_counter_next = '0;
          parse_phase_next  = PH_AFIX;
        end else begin
          byte_counter_next = byte_counter + 4'd1;
        end
      end
      PH_AFIX: begin
        if (byte_counter == AFIX_LAST) begin
          byte_counter_next = '0;
          parse_phase_next  = PH_ALEN;
        end else begin
          byte_counter_next = byte_counter + 4'd1;
        end
      end
      PH_ALEN: begin
        record_length_next = {record_length[7:0], b};
        if (byte_counter == PAIR_LAST) begin
          byte_counter_next = '0;
          record_type_next  = '0;
          if (record_type == TYPE_ADDR) begin
            record_length_next = '0;
            if ({record_length[7:0], b} != ADDR_LEN) begin
              emit        = 1'b1;
              emit_status = ST_BAD_LENGTH;
            end else begin
              parse_phase_next = PH_ADDR;
            end
          end else if ({record_length[7:0], b} == 16'd0) begin
            parse_phase_next = PH_ANAME_FIRST;
          end else begin
            parse_phase_next = PH_ADATA;
          end
        end else begin
          byte_counter_next = byte_counter + 4'd1;
        end
      end
      PH_ADDR: begin
        address_accumulator_next = {address_accumulator[23:0], b};
        if (byte_counter == ADDR_LAST) begin
          byte_counter_next = '0;
          emit              = 1'b1;
          emit_status       = ST_FOUND;
          emit_address      = {address_accumulator[23:0], b};
        end else begin
          byte_counter_next = byte_counter + 4'd1;
        end
      end
      PH_ADATA: begin
        record_length_next = record_length - 16'd1;
        if (record_length == 16'd1) begin
          parse_phase_next = PH_ANAME_FIRST;
        end
      end
      default: begin
      end
    endcase

    if (emit) begin
      reported_next    = 1'b1;
      parse_phase_next = PH_DONE;
    end

    // The final byte closes the message: report a miss if nothing was given.
    if (in.last) begin
      if (!emit && !reported) begin
        emit         = 1'b1;
        emit_status  = ST_NOT_FOUND;
        emit_address = '0;
      end
      parse_phase_next         = PH_HDR;
      byte_counter_next        = '0;
      captured_id_next         = '0;
      answers_present_next     = 1'b0;
      record_type_next         = '0;
      record_length_next       = '0;
      address_accumulator_next = '0;
      reported_next            = 1'b0;
    end
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase         <= PH_HDR;
      byte_counter        <= '0;
      captured_id         <= '0;
      answers_present     <= 1'b0;
      record_type         <= '0;
      record_length       <= '0;
      address_accumulator <= '0;
      reported            <= 1'b0;
    end else if (accept) begin
      parse_phase         <= parse_phase_next;
      byte_counter        <= byte_counter_next;
      captured_id         <= captured_id_next;
      answers_present     <= answers_present_next;
      record_type         <= record_type_next;
      record_length       <= record_length_next;
      address_accumulator <= address_accumulator_next;
      reported            <= reported_next;
    end
  end

  // Output register: loaded by a result beat, cleared when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && emit) begin
      out_valid <= 1'b1;
    end else if (out.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_status  <= emit_status;
      out_address <= emit_address;
    end
  end

endmodule : dns_answer_address_parser_top

`default_nettype wire

FILE: design/dnsap_checker.sv
// ----------------------------------------------------------------------------
// DNS answer address parser checker
// Port-level checks on the result channel and input ready, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dnsap_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire dnsap_pkg::status_t  out_status,
  input wire dnsap_pkg::address_t out_address
);
  import dnsap_pkg::*;

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_address))
    else $error("result beat changed while stalled");

  // A new result beat is only ever loaded by an accepted byte.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("result beat without an accepted byte");

  // The address is zero unless an address was found.
  a_addr_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status != ST_FOUND |-> out_address == '0)
    else $error("address set on a failure status");

  // Status stays within its defined codes.
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_status <= ST_NOT_FOUND)
    else $error("undefined status code");

  // Input is never refused while the output register is empty.
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

endmodule : dnsap_checker

bind dns_answer_address_parser_top dnsap_checker u_dnsap_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in.valid),
  .in_ready    (in.ready),
  .out_valid   (out.valid),
  .out_ready   (out.ready),
  .out_status  (out.status),
  .out_address (out.address)
);

`default_nettype wire

FILE: verif/tb_dns_answer_address_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNS answer address parser testbench
// Feeds DNS response payloads one byte per beat, predicts the single status
// result of each message and compares every result beat against the
// prediction. The run has a directed table of messages, then random
// well-formed, broken and noise messages under several transaction ids,
// with random idling on both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------

module tb_dns_answer_address_parser_top;
  import dnsap_pkg::*;

  // Timing and run sizes.
  localparam int          CLK_HALF_NS     = 2;
  localparam int          RESET_CYCLES    = 7;
  localparam int          DRAIN_CYCLES    = 4;
  localparam int          HOLD_CYCLES     = 300;
  localparam int          PHASES          = 6;
  localparam int          BYTES_PER_PHASE = 170;
  localparam int          SHOW_LIMIT      = 10;
  localparam longint      TIMEOUT_NS      = 1_000_000;

  // Message layout.
  localparam int          HDR_BYTES    = 12;
  localparam int          QTAIL_BYTES  = 4;
  localparam int          RFIXED_BYTES = 6;
  localparam int          A_LEN        = 4;
  localparam logic [15:0] TYPE_A       = 16'h0001;
  localparam payload_t    PTR_MARK     = 8'hc0;

  // Directed table layout.
  localparam int          MAXB     = 48;
  localparam int          DIR_ROWS = 15;
  localparam logic [95:0] HDR_OK   = 96'h0000_8180_0001_0001_0000_0000;
  localparam logic [47:0] CLS_TTL  = 48'h0001_0000_0e10;

  typedef enum logic [3:0] {
    P_HEADER, P_QNAME_LEAD, P_QNAME_BODY, P_QNAME_PTR, P_QTAIL,
    P_ANAME_LEAD, P_ANAME_BODY, P_ANAME_PTR, P_RTYPE, P_RFIXED,
    P_RDLEN, P_RADDR, P_RDATA, P_DONE
  } parse_phase_e;

  typedef struct packed {
    status_t  status;
    address_t address;
  } lookup_t;

  typedef logic [8*MAXB-1:0] row_bytes_t;

  typedef struct packed {
    logic [7:0] nbytes;
    row_bytes_t data;
    logic       typed;
    status_t    status;
    address_t   address;
  } dir_row_t;

  logic    clk = 1'b0;
  logic    rst;
  logic    cfg_we;
  txn_id_t cfg_wdata;

  dnsap_in_if  in_ch ();
  dnsap_out_if out_ch ();

  dns_answer_address_parser_top dut (
    .clk       (clk),
    .rst       (rst),
    .in        (in_ch),
    .out       (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #(CLK_HALF_NS) clk = ~clk;

  // Predictor state, a private copy of the parser and its register.
  txn_id_t      id_reg;
  parse_phase_e pr_phase;
  logic [15:0]  pr_count;
  txn_id_t      pr_id;
  logic         pr_has_ans;
  logic [15:0]  pr_type;
  logic [15:0]  pr_len;
  address_t     pr_acc;
  logic         pr_reported;

  lookup_t      pending_lookups [$];
  dir_row_t     dir_tab [DIR_ROWS];
  dir_row_t     row;

  bit           send_idle;
  bit           recv_idle;
  int unsigned  hold_request;
  int           error_count;
  int           msg_count;
  int           bytes_sent;
  int           results_seen;
  int           found_count;
  int           id_writes;

  task automatic flag_error(input string msg);
    if (error_count < SHOW_LIMIT) $display("[%0t] mismatch: %s", $time, msg);
    error_count++;
  endtask

  // Return the parser to the start of a message.
  task automatic clear_parse();
    pr_phase    = P_HEADER;
    pr_count    = '0;
    pr_id       = '0;
    pr_has_ans  = 1'b0;
    pr_type     = '0;
    pr_len      = '0;
    pr_acc      = '0;
    pr_reported = 1'b0;
  endtask

  // Classify the first byte of a name: pointer, empty name or labels.
  function automatic parse_phase_e name_lead(input payload_t b, input parse_phase_e ptr_ph,
                                             input parse_phase_e body_ph,
                                             input parse_phase_e after_ph);
    if ((b & PTR_MARK) == PTR_MARK) return ptr_ph;
    if (b == 8'h00) return after_ph;
    return body_ph;
  endfunction

  // Advance the predicted parser by one byte and give the result it causes.
  task automatic dns_parse_byte(input payload_t b, input logic lst, output bit hit,
                                output lookup_t res);
    hit = 1'b0;
    res = '0;
    case (pr_phase)
      P_HEADER: begin
        if (pr_count == 0) pr_id = {b, 8'h00};
        else if (pr_count == 1) pr_id[7:0] = b;
        else if ((pr_count == 6 || pr_count == 7) && b != 8'h00) pr_has_ans = 1'b1;
        if (pr_count == HDR_BYTES - 1) begin
          pr_count = '0;
          if (!pr_has_ans) begin
            hit = 1'b1;
            res.status = ST_NO_ANSWERS;
            pr_phase = P_DONE;
          end else if (pr_id != id_reg) begin
            hit = 1'b1;
            res.status = ST_WRONG_ID;
            pr_phase = P_DONE;
          end else begin
            pr_phase = P_QNAME_LEAD;
          end
        end else begin
          pr_count++;
        end
      end
      P_QNAME_LEAD: pr_phase = name_lead(b, P_QNAME_PTR, P_QNAME_BODY, P_QTAIL);
      P_QNAME_BODY: if (b == 8'h00) pr_phase = P_QTAIL;
      P_QNAME_PTR:  pr_phase = P_QTAIL;
      P_QTAIL: begin
        if (pr_count == QTAIL_BYTES - 1) begin
          pr_count = '0;
          pr_phase = P_ANAME_LEAD;
        end else begin
          pr_count++;
        end
      end
      P_ANAME_LEAD: begin
        pr_phase = name_lead(b, P_ANAME_PTR, P_ANAME_BODY, P_RTYPE);
        pr_count = '0;
      end
      P_ANAME_BODY: if (b == 8'h00) pr_phase = P_RTYPE;
      P_ANAME_PTR:  pr_phase = P_RTYPE;
      P_RTYPE: begin
        pr_type = {pr_type[7:0], b};
        if (pr_count == 1) begin
          pr_count = '0;
          pr_phase = P_RFIXED;
        end else begin
          pr_count++;
        end
      end
      P_RFIXED: begin
        if (pr_count == RFIXED_BYTES - 1) begin
          pr_count = '0;
          pr_phase = P_RDLEN;
        end else begin
          pr_count++;
        end
      end
      P_RDLEN: begin
        pr_len = {pr_len[7:0], b};
        if (pr_count == 1) begin
          pr_count = '0;
          if (pr_type == TYPE_A) begin
            if (pr_len != A_LEN) begin
              hit = 1'b1;
              res.status = ST_BAD_LENGTH;
              pr_phase = P_DONE;
            end else begin
              pr_phase = P_RADDR;
            end
          end else if (pr_len == 16'h0000) begin
            pr_phase = P_ANAME_LEAD;
          end else begin
            pr_phase = P_RDATA;
          end
          pr_type = '0;
          if (pr_phase != P_RDATA) pr_len = '0;
        end else begin
          pr_count++;
        end
      end
      P_RADDR: begin
        pr_acc = {pr_acc[23:0], b};
        if (pr_count == A_LEN - 1) begin
          pr_count = '0;
          hit = 1'b1;
          res.status = ST_FOUND;
          res.address = pr_acc;
          pr_phase = P_DONE;
        end else begin
          pr_count++;
        end
      end
      P_RDATA: begin
        pr_len = pr_len - 16'd1;
        if (pr_len == 16'h0000) pr_phase = P_ANAME_LEAD;
      end
      default: ;
    endcase
    if (hit) pr_reported = 1'b1;
    // The final byte closes the message, with a not-found report if nothing came.
    if (lst) begin
      if (!hit && !pr_reported) begin
        hit = 1'b1;
        res.status = ST_NOT_FOUND;
        res.address = '0;
      end
      clear_parse();
    end
  endtask

  // Offer one byte after a random gap and predict once the beat is taken.
  task automatic send_byte(input payload_t b, input logic lst, input bit typed,
                           input lookup_t typed_res);
    int      gap;
    bit      hit;
    lookup_t res;
    gap = send_idle ? $urandom_range(0, 16) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) begin
        in_ch.payload_byte = payload_t'($urandom);
        in_ch.last         = 1'($urandom_range(0, 1));
        @(negedge clk);
      end
    end
    in_ch.valid        = 1'b1;
    in_ch.payload_byte = b;
    in_ch.last         = lst;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
    dns_parse_byte(b, lst, hit, res);
    if (hit) pending_lookups.push_back(typed ? typed_res : res);
  endtask

  task automatic send_message(input payload_t m[$]);
    for (int i = 0; i < m.size(); i++) send_byte(m[i], i == m.size() - 1, 1'b0, '0);
    msg_count++;
  endtask

  // Stop offering and wait until every predicted result has been taken.
  task automatic wait_all_answered();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_expected_id(input txn_id_t v);
    wait_all_answered();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we    = 1'b0;
    id_reg    = v;
    id_writes++;
  endtask

  // A name as a pointer, an empty name or a run of nonzero bytes and a zero.
  task automatic add_name(inout payload_t m[$]);
    case ($urandom_range(0, 3))
      0: m.push_back(8'h00);
      1: begin
        m.push_back(PTR_MARK | payload_t'($urandom_range(0, 63)));
        m.push_back(payload_t'($urandom));
      end
      default: begin
        m.push_back(payload_t'($urandom_range(1, 8'hbf)));
        repeat ($urandom_range(0, 10)) m.push_back(payload_t'($urandom_range(1, 255)));
        m.push_back(8'h00);
      end
    endcase
  endtask

  // A response of random content, mostly well formed, sometimes cut short.
  task automatic build_response(output payload_t m[$]);
    int          cut;
    logic [15:0] hdr_id;
    logic [15:0] ancnt;
    logic [15:0] rtype;
    logic [15:0] rlen;
    m = {};
    hdr_id = ($urandom_range(0, 7) == 0) ? 16'($urandom) : id_reg;
    case ($urandom_range(0, 9))
      0:       ancnt = 16'h0000;
      1:       ancnt = 16'($urandom);
      default: ancnt = 16'($urandom_range(1, 3));
    endcase
    m.push_back(hdr_id[15:8]);
    m.push_back(hdr_id[7:0]);
    repeat (4) m.push_back(payload_t'($urandom));
    m.push_back(ancnt[15:8]);
    m.push_back(ancnt[7:0]);
    repeat (4) m.push_back(payload_t'($urandom));
    add_name(m);
    repeat (QTAIL_BYTES) m.push_back(payload_t'($urandom));
    repeat ($urandom_range(1, 3)) begin
      add_name(m);
      case ($urandom_range(0, 5))
        0, 1, 2: rtype = TYPE_A;
        3:       rtype = 16'h0005;
        4:       rtype = 16'h001c;
        default: rtype = 16'($urandom);
      endcase
      if (rtype == TYPE_A)
        rlen = ($urandom_range(0, 5) == 0) ? 16'($urandom_range(0, 8)) : 16'(A_LEN);
      else
        rlen = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12));
      m.push_back(rtype[15:8]);
      m.push_back(rtype[7:0]);
      repeat (RFIXED_BYTES) m.push_back(payload_t'($urandom));
      m.push_back(rlen[15:8]);
      m.push_back(rlen[7:0]);
      repeat ((rlen > 24) ? 24 : rlen) m.push_back(payload_t'($urandom));
    end
    repeat ($urandom_range(0, 3)) m.push_back(payload_t'($urandom));
    if ($urandom_range(0, 7) == 0) begin
      cut = $urandom_range(1, m.size());
      m = m[0:cut-1];
    end
  endtask

  // Receiving side: random stalls, one long hold-off on request, checking.
  initial begin : result_sink
    int      gap;
    int      hold_left;
    lookup_t want;
    out_ch.ready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
        out_ch.ready = 1'b0;
        for (int c = 1; c < hold_left; c++) @(negedge clk);
      end else begin
        gap = recv_idle ? $urandom_range(0, 16) : 0;
        if (gap > 0) begin
          out_ch.ready = 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      // One result beat taken: compare it with the oldest prediction.
      results_seen++;
      if (out_ch.status == ST_FOUND) found_count++;
      if (pending_lookups.size() == 0) begin
        flag_error($sformatf("unexpected result, status %0d address %h",
                             out_ch.status, out_ch.address));
      end else begin
        want = pending_lookups.pop_front();
        if (out_ch.status !== want.status)
          flag_error($sformatf("status expected %0d actual %0d", want.status, out_ch.status));
        if (out_ch.address !== want.address)
          flag_error($sformatf("address expected %h actual %h", want.address,
                               out_ch.address));
      end
    end
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("[%0t] run did not finish in time, %0d results outstanding", $time,
             pending_lookups.size());
    $display("FAIL dns_answer_address_parser_top");
    $finish;
  end

  // Directed messages: byte count, bytes in arrival order, and a typed
  // result where it is plain from the bytes; other rows use the predictor.
  initial begin : fill_table
    dir_tab[0]  = '{8'd12, row_bytes_t'(96'h0000_8180_0001_0000_0000_0000), 1'b1,
                    ST_NO_ANSWERS, 32'h0};
    dir_tab[1]  = '{8'd12, row_bytes_t'(96'habcd_8180_0001_0000_0000_0000), 1'b1,
                    ST_NO_ANSWERS, 32'h0};
    dir_tab[2]  = '{8'd12, row_bytes_t'(96'habcd_8180_0001_0001_0000_0000), 1'b1,
                    ST_WRONG_ID, 32'h0};
    // Answer count set in its high byte only; bytes after the report are ignored.
    dir_tab[3]  = '{8'd16, row_bytes_t'(128'hffff_0000_0000_0100_0000_0000_ffff_ffff),
                    1'b1, ST_WRONG_ID, 32'h0};
    // Pointer names throughout and an all-ones address.
    dir_tab[4]  = '{8'd34, row_bytes_t'({HDR_OK, 16'hc00c, 32'h0001_0001, 16'hc00c,
                    TYPE_A, CLS_TTL, 16'h0004, 32'hffff_ffff}), 1'b1, ST_FOUND,
                    32'hffff_ffff};
    // Label question name, empty answer name, zero address, trailing bytes.
    dir_tab[5]  = '{8'd38, row_bytes_t'({HDR_OK, 40'h03_7777_7700, 32'h0001_0001, 8'h00,
                    TYPE_A, CLS_TTL, 16'h0004, 32'h0000_0000, 16'hc0ff}), 1'b1, ST_FOUND,
                    32'h0};
    // Address record with a length other than four.
    dir_tab[6]  = '{8'd30, row_bytes_t'({HDR_OK, 16'hc00c, 32'h0001_0001, 16'hc00c,
                    TYPE_A, CLS_TTL, 16'h0010}), 1'b1, ST_BAD_LENGTH, 32'h0};
    // Other record of zero length, then the address record.
    dir_tab[7]  = '{8'd46, row_bytes_t'({HDR_OK, 16'hc00c, 32'h0001_0001, 16'hc00c,
                    16'h0005, CLS_TTL, 16'h0000, 16'hc02b, TYPE_A, CLS_TTL, 16'h0004,
                    32'h0a00_0001}), 1'b0, ST_FOUND, 32'h0};
    // Other record with data holding zeros; non-pointer name led by 0xbf.
    dir_tab[8]  = '{8'd48, row_bytes_t'({96'h0000_8180_0001_0002_0000_0000, 8'h00,
                    32'h0001_0001, 24'hbf_8000, 16'h0005, CLS_TTL, 16'h0003, 24'h01_0000,
                    8'h00, TYPE_A, CLS_TTL, 16'h0004, 32'hc0a8_0101}), 1'b0, ST_FOUND,
                    32'h0};
    // Truncated inside a question name led by 0x40.
    dir_tab[9]  = '{8'd15, row_bytes_t'({HDR_OK, 24'h40_4142}), 1'b1, ST_NOT_FOUND,
                    32'h0};
    // A message of one byte.
    dir_tab[10] = '{8'd1, row_bytes_t'(8'h00), 1'b1, ST_NOT_FOUND, 32'h0};
    // Only a mail exchange record, ending on its last data byte.
    dir_tab[11] = '{8'd32, row_bytes_t'({HDR_OK, 16'hc00c, 32'h0001_0001, 16'hc00c,
                    16'h000f, CLS_TTL, 16'h0002, 16'h000a}), 1'b1, ST_NOT_FOUND, 32'h0};
    // Type with the address code in its high byte is skipped.
    dir_tab[12] = '{8'd32, row_bytes_t'({HDR_OK, 8'h00, 32'h0001_0001, 8'h00, 16'h0101,
                    CLS_TTL, 16'h0004, 32'h0102_0304}), 1'b0, ST_FOUND, 32'h0};
    // Good header ending on its twelfth byte.
    dir_tab[13] = '{8'd12, row_bytes_t'(96'h0000_0100_0001_0002_0000_0000), 1'b1,
                    ST_NOT_FOUND, 32'h0};
    // Question name given as a pointer led by 0xff.
    dir_tab[14] = '{8'd34, row_bytes_t'({HDR_OK, 16'hffff, 32'h0001_0001, 16'hc00c,
                    TYPE_A, CLS_TTL, 16'h0004, 32'h7f00_0001}), 1'b0, ST_FOUND, 32'h0};
  end

  // Stimulus.
  initial begin : stimulus
    payload_t m [$];
    int       phase_bytes;
    txn_id_t  next_id;
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.payload_byte = '0;
    in_ch.last         = 1'b0;
    hold_request       = 0;
    error_count        = 0;
    msg_count          = 0;
    bytes_sent         = 0;
    results_seen       = 0;
    found_count        = 0;
    id_writes          = 0;
    id_reg             = '0;
    clear_parse();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table, under the register's reset value.
    send_idle = 1'b1;
    recv_idle = 1'b1;
    for (int r = 0; r < DIR_ROWS; r++) begin
      row = dir_tab[r];
      for (int i = 0; i < row.nbytes; i++)
        send_byte(row.data[8*(row.nbytes-1-i) +: 8], i == row.nbytes - 1, row.typed,
                  '{row.status, row.address});
      msg_count++;
    end

    // Random phases, each under its own transaction id and idling pattern.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       next_id = 16'hffff;
        1:       next_id = 16'h0000;
        3:       next_id = 16'h8001;
        5:       next_id = 16'h7ffe;
        default: next_id = txn_id_t'($urandom);
      endcase
      write_expected_id(next_id);
      send_idle = (ph != 0 && ph != 2);
      recv_idle = (ph != 0 && ph != 3);
      phase_bytes = 0;
      if (ph == 2) begin
        // Short no-answer messages pile up behind a long receiver hold-off.
        hold_request = HOLD_CYCLES;
        repeat (12) begin
          m = {};
          repeat (HDR_BYTES) m.push_back(payload_t'($urandom));
          m[6] = 8'h00;
          m[7] = 8'h00;
          send_message(m);
          phase_bytes += m.size();
        end
      end
      while (phase_bytes < BYTES_PER_PHASE) begin
        if ($urandom_range(0, 6) == 0) begin
          m = {};
          repeat ($urandom_range(1, 40)) m.push_back(payload_t'($urandom));
        end else begin
          build_response(m);
        end
        send_message(m);
        phase_bytes += m.size();
      end
    end

    wait_all_answered();
    $display("Covered %0d messages in %0d payload bytes under %0d transaction ids;",
             msg_count, bytes_sent, id_writes + 1);
    $display("%0d results taken, %0d with an address, %0d mismatches.", results_seen,
             found_count, error_count);
    if (error_count == 0) begin
      $display("PASS dns_answer_address_parser_top");
    end else begin
      $display("FAIL dns_answer_address_parser_top");
    end
    $finish;
  end

endmodule
